>>> rtl/core/lwf_pkg.sv
// ============================================================================
// lwf_pkg
// shared types, command codes and constants of the lcd window fill command
// generator
// ============================================================================
package lwf_pkg;

    // controller command bytes
    localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
    localparam logic [7:0] CMD_PAGE_SET   = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;

    // request kinds
    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_RECT  = 2'd1;
    localparam logic [1:0] OP_TRACE = 2'd2;

    // configuration register indexes
    localparam int         CFG_INDEX_W        = 8;
    localparam int         CFG_DATA_W         = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_ERASE_COLOR    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRACE_X_OFFSET = 8'd1;

    localparam logic [7:0] RESET_X_OFFSET = 8'd25;

    // default depth of the queue between front and back
    localparam int LWF_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] x_start;
        logic [15:0] y_start;
        logic [15:0] x_end;
        logic [15:0] y_end;
        logic [15:0] color;
        logic [7:0]  old_sample;
        logic [7:0]  new_sample;
        logic        first_column;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  command;
        logic [15:0] first_param;
        logic [15:0] second_param;
        logic [15:0] fill_color;
        logic [32:0] fill_count;
        logic        last_of_run;
    } out_item_t;

    typedef enum logic {
        KIND_WINDOW,
        KIND_TRACE
    } kind_t;

    // one classified request, as the back end plays it out
    typedef struct packed {
        kind_t       kind;
        logic [15:0] col_first;
        logic [15:0] col_second;
        logic [15:0] page_a_first;
        logic [15:0] page_a_second;
        logic [15:0] fill_a_color;
        logic [16:0] width;
        logic [16:0] height;
        logic [7:0]  page_b_first;
        logic [7:0]  page_b_second;
        logic [15:0] fill_b_color;
        logic [8:0]  fill_b_count;
    } desc_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

>>> rtl/core/lwf_front.sv
// ============================================================================
// lwf_front
// accepts drawing requests, holds configuration and trace state, and turns
// each pixel, rectangle or trace request into one queue descriptor
// ============================================================================
module lwf_front
    import lwf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_payload,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  q_status_t              q_status,
    output logic                   q_push,
    output desc_t                  q_push_data
);

    logic [15:0] erase_color_reg;
    logic [7:0]  x_offset_reg;
    logic [7:0]  prev_old_reg, prev_old_next;
    logic [7:0]  prev_new_reg, prev_new_next;
    logic [7:0]  column_reg,   column_next;

    logic        accept;
    logic [7:0]  base_old, base_new, base_col, col;
    logic [7:0]  old_lo, old_hi, new_lo, new_hi;
    logic [16:0] rect_w, rect_h;
    logic        rect_ok;
    desc_t       desc;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        // trace column operands, restart takes the current samples
        base_old = s_payload.first_column ? s_payload.old_sample : prev_old_reg;
        base_new = s_payload.first_column ? s_payload.new_sample : prev_new_reg;
        base_col = s_payload.first_column ? 8'd0 : column_reg;
        col      = x_offset_reg + base_col;
        old_lo   = (base_old < s_payload.old_sample) ? base_old : s_payload.old_sample;
        old_hi   = (base_old < s_payload.old_sample) ? s_payload.old_sample : base_old;
        new_lo   = (base_new < s_payload.new_sample) ? base_new : s_payload.new_sample;
        new_hi   = (base_new < s_payload.new_sample) ? s_payload.new_sample : base_new;

        // rectangle size, empty when an end lies below its start
        rect_ok = (s_payload.x_end >= s_payload.x_start) &&
                  (s_payload.y_end >= s_payload.y_start);
        rect_w  = {1'b0, s_payload.x_end} - {1'b0, s_payload.x_start} + 17'd1;
        rect_h  = {1'b0, s_payload.y_end} - {1'b0, s_payload.y_start} + 17'd1;

        desc               = '0;
        desc.kind          = KIND_WINDOW;
        desc.fill_a_color  = s_payload.color;
        desc.fill_b_color  = s_payload.color;
        q_push             = 1'b0;
        prev_old_next      = prev_old_reg;
        prev_new_next      = prev_new_reg;
        column_next        = column_reg;

        case (s_payload.op)
            OP_PIXEL: begin
                q_push             = accept;
                desc.col_first     = s_payload.x_start;
                desc.col_second    = s_payload.x_start;
                desc.page_a_first  = s_payload.y_start;
                desc.page_a_second = s_payload.y_start;
                desc.width         = 17'd1;
                desc.height        = 17'd1;
            end
            OP_RECT: begin
                q_push             = accept;
                desc.col_first     = s_payload.x_start;
                desc.col_second    = s_payload.x_end;
                desc.page_a_first  = s_payload.y_start;
                desc.page_a_second = s_payload.y_end;
                desc.width         = rect_ok ? rect_w : 17'd0;
                desc.height        = rect_ok ? rect_h : 17'd0;
            end
            OP_TRACE: begin
                q_push             = accept;
                desc.kind          = KIND_TRACE;
                desc.col_first     = {8'd0, col};
                desc.col_second    = {8'd0, col};
                desc.page_a_first  = {8'd0, old_lo};
                desc.page_a_second = {8'd0, old_hi};
                desc.fill_a_color  = erase_color_reg;
                desc.width         = {8'd0, {1'b0, old_hi} - {1'b0, old_lo} + 9'd1};
                desc.height        = 17'd1;
                desc.page_b_first  = new_lo;
                desc.page_b_second = new_hi;
                desc.fill_b_count  = {1'b0, new_hi} - {1'b0, new_lo} + 9'd1;
                if (accept) begin
                    prev_old_next = s_payload.old_sample;
                    prev_new_next = s_payload.new_sample;
                    column_next   = base_col + 8'd1;
                end
            end
            default: begin
                q_push = 1'b0;
            end
        endcase
        q_push_data = desc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            erase_color_reg <= '0;
            x_offset_reg    <= RESET_X_OFFSET;
            prev_old_reg    <= '0;
            prev_new_reg    <= '0;
            column_reg      <= '0;
        end else begin
            if (cfg_valid && (cfg_index == CFG_ERASE_COLOR)) begin
                erase_color_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == CFG_TRACE_X_OFFSET)) begin
                x_offset_reg <= cfg_data[7:0];
            end
            prev_old_reg <= prev_old_next;
            prev_new_reg <= prev_new_next;
            column_reg   <= column_next;
        end
    end

endmodule

>>> rtl/core/lwf_queue.sv
// ============================================================================
// lwf_queue
// small descriptor queue between front and back
// ============================================================================
module lwf_queue
    import lwf_pkg::*;
#(
    parameter int DEPTH = LWF_QUEUE_DEPTH
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  desc_t     push_data,
    input  logic      pop,
    output desc_t     head,
    output q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign status.empty = (count_reg == CNT_W'(0));
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign head         = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!status.full || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !status.empty)
        else $error("queue pop while empty");

endmodule

>>> rtl/core/lwf_back.sv
// ============================================================================
// lwf_back
// plays the head descriptor out as controller commands, one per cycle,
// through the output register while the sink does not stall it
// ============================================================================
module lwf_back
    import lwf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  desc_t     head,
    input  q_status_t q_status,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    typedef enum logic [4:0] {
        STEP_COL    = 5'b00001,
        STEP_PAGE_A = 5'b00010,
        STEP_FILL_A = 5'b00100,
        STEP_PAGE_B = 5'b01000,
        STEP_FILL_B = 5'b10000
    } step_t;

    step_t       step_reg, step_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   out_reg, out_next;
    logic        load, advance;
    logic [33:0] product;

    assign load      = !m_valid_reg || m_ready;
    assign advance   = load && !q_status.empty;
    assign product   = head.width * head.height;
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    always_comb begin
        out_next     = '0;
        step_next    = step_reg;
        q_pop        = 1'b0;
        m_valid_next = load ? !q_status.empty : m_valid_reg;
        case (step_reg)
            STEP_COL: begin
                out_next.command      = CMD_COLUMN_SET;
                out_next.first_param  = head.col_first;
                out_next.second_param = head.col_second;
                step_next             = STEP_PAGE_A;
            end
            STEP_PAGE_A: begin
                out_next.command      = CMD_PAGE_SET;
                out_next.first_param  = head.page_a_first;
                out_next.second_param = head.page_a_second;
                step_next             = STEP_FILL_A;
            end
            STEP_FILL_A: begin
                out_next.command     = CMD_MEM_WRITE;
                out_next.fill_color  = head.fill_a_color;
                out_next.fill_count  = product[32:0];
                out_next.last_of_run = (head.kind == KIND_WINDOW);
                if (head.kind == KIND_WINDOW) begin
                    step_next = STEP_COL;
                    q_pop     = advance;
                end else begin
                    step_next = STEP_PAGE_B;
                end
            end
            STEP_PAGE_B: begin
                out_next.command      = CMD_PAGE_SET;
                out_next.first_param  = {8'd0, head.page_b_first};
                out_next.second_param = {8'd0, head.page_b_second};
                step_next             = STEP_FILL_B;
            end
            STEP_FILL_B: begin
                out_next.command     = CMD_MEM_WRITE;
                out_next.fill_color  = head.fill_b_color;
                out_next.fill_count  = {24'd0, head.fill_b_count};
                out_next.last_of_run = 1'b1;
                step_next            = STEP_COL;
                q_pop                = advance;
            end
            default: begin
                step_next = STEP_COL;
            end
        endcase
        if (!advance) begin
            step_next = step_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= STEP_COL;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    a_head_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg != STEP_COL) |-> !q_status.empty)
        else $error("request left the queue before its last command");

    a_set_has_no_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (out_reg.command != CMD_MEM_WRITE)) |->
        ((out_reg.fill_count == 33'd0) && (out_reg.fill_color == 16'd0)))
        else $error("set command carries a fill run");

    a_last_is_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.last_of_run) |-> (out_reg.command == CMD_MEM_WRITE))
        else $error("run ends on a command other than memory write");

endmodule

>>> rtl/core/lcd_window_fill_command_generator.sv
// ============================================================================
// lcd_window_fill_command_generator
// turns pixel, rectangle and scope trace column requests into display
// controller window and fill commands
// ============================================================================
// Each accepted request becomes a short run of commands on the m_ side: a
// pixel or rectangle gives column set, page set and memory write (three
// commands), a trace column gives column set and two page set / memory write
// pairs, erase span then draw span (five commands); last_of_run marks the
// final one and an op of 3 gives none. The front accepts a request in any
// cycle in which the descriptor queue has room (QUEUE_DEPTH entries), so
// requests arrive back to back while earlier ones are still being played
// out. The back end issues one command per cycle from the queue head into
// the output register while the sink is not stalling it, and pops a request
// only with its final command, so every run goes through that one stream.
// The rectangle pixel count comes from a 17 x 17 multiply ahead of the
// output register. Configuration writes (cfg_index 0 erase color, 1 trace
// x offset) are always taken and should only be issued while the block is
// idle.
// ============================================================================
module lcd_window_fill_command_generator
    import lwf_pkg::*;
#(
    parameter int QUEUE_DEPTH = LWF_QUEUE_DEPTH
)
(
    input  logic                   aclk,
    input  logic                   aresetn,

    // request transactions
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_payload,

    // command transactions
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_payload,

    // configuration write transactions
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // front to queue
    logic      q_push;
    desc_t     q_push_data;

    // queue to back
    desc_t     q_head;
    logic      q_pop;
    q_status_t q_status;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // classification, configuration and trace state
    lwf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    // decouples request acceptance from command issue
    lwf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    // command sequencer and output register
    lwf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (q_head),
        .q_status  (q_status),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

>>> sim/tb_lcd_window_fill_command_generator.sv
// ============================================================================
// tb_lcd_window_fill_command_generator
// self-checking bench for the lcd window fill command generator: a directed
// table, then random pixel, rectangle and trace requests, mostly under random
// source and sink stalls, every command checked on typed values or a predictor
// ============================================================================
module tb_lcd_window_fill_command_generator;
    import lwf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // op code the block must swallow without any command
    localparam logic [1:0] OP_NONE = 2'd3;
    // first register index that maps to nothing
    localparam int CFG_FIRST_UNUSED = 2;
    localparam int MAX_GAP = 18;
    localparam int unsigned CYCLE_LIMIT = 400_000;
    // use the predictor instead of typed-in commands
    localparam int PREDICTED = -1;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_payload;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_payload;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    lcd_window_fill_command_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor copy of registers and trace state
    logic [15:0] erase_col;
    logic [7:0]  x_offset;
    logic [7:0]  prev_old;
    logic [7:0]  prev_new;
    logic [7:0]  trace_col;

    out_item_t   planned_cmds [$];   // commands of the request being sent
    out_item_t   pending_cmds [$];   // commands still owed by the block

    // directed table: requests, typed command count (or predicted), commands
    in_item_t    dir_reqs [$];
    int          dir_typed_n [$];
    out_item_t   typed_cmds [$];

    bit          source_idle;
    bit          sink_idle;
    int          fail_count = 0;
    int unsigned cycle_count = 0;

    function automatic out_item_t mk_cmd(input logic [7:0] c, input logic [15:0] p0,
                                         input logic [15:0] p1, input logic [15:0] colr,
                                         input logic [32:0] cnt, input logic last);
        out_item_t o;
        o.command      = c;
        o.first_param  = p0;
        o.second_param = p1;
        o.fill_color   = colr;
        o.fill_count   = cnt;
        o.last_of_run  = last;
        return o;
    endfunction

    function automatic in_item_t mk_req(input logic [1:0] op, input logic [15:0] xs,
                                        input logic [15:0] ys, input logic [15:0] xe,
                                        input logic [15:0] ye, input logic [15:0] colr,
                                        input logic [7:0] olds, input logic [7:0] news,
                                        input logic first);
        in_item_t r;
        r.op           = op;
        r.x_start      = xs;
        r.y_start      = ys;
        r.x_end        = xe;
        r.y_end        = ye;
        r.color        = colr;
        r.old_sample   = olds;
        r.new_sample   = news;
        r.first_column = first;
        return r;
    endfunction

    // page set over the rows between a and b, then a fill of that span
    function automatic void plan_span(input logic [7:0] a, input logic [7:0] b,
                                      input logic [15:0] colr, input logic last);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        planned_cmds.push_back(mk_cmd(CMD_PAGE_SET, {8'b0, lo}, {8'b0, hi}, '0, '0, 1'b0));
        planned_cmds.push_back(mk_cmd(CMD_MEM_WRITE, '0, '0, colr,
                                      {25'b0, hi - lo} + 33'd1, last));
    endfunction

    // expected command run of one request, trace state advanced as the block does
    function automatic void plan_commands(input in_item_t r);
        logic [16:0] w;
        logic [16:0] h;
        logic [32:0] px;
        logic [7:0]  col;
        planned_cmds.delete();
        case (r.op)
            OP_PIXEL: begin
                planned_cmds.push_back(mk_cmd(CMD_COLUMN_SET, r.x_start, r.x_start,
                                              '0, '0, 1'b0));
                planned_cmds.push_back(mk_cmd(CMD_PAGE_SET, r.y_start, r.y_start,
                                              '0, '0, 1'b0));
                planned_cmds.push_back(mk_cmd(CMD_MEM_WRITE, '0, '0, r.color, 33'd1, 1'b1));
            end
            OP_RECT: begin
                // inverted window fills nothing
                px = '0;
                if (r.x_end >= r.x_start && r.y_end >= r.y_start) begin
                    w  = {1'b0, r.x_end} - {1'b0, r.x_start} + 17'd1;
                    h  = {1'b0, r.y_end} - {1'b0, r.y_start} + 17'd1;
                    px = {16'b0, w} * {16'b0, h};
                end
                planned_cmds.push_back(mk_cmd(CMD_COLUMN_SET, r.x_start, r.x_end,
                                              '0, '0, 1'b0));
                planned_cmds.push_back(mk_cmd(CMD_PAGE_SET, r.y_start, r.y_end,
                                              '0, '0, 1'b0));
                planned_cmds.push_back(mk_cmd(CMD_MEM_WRITE, '0, '0, r.color, px, 1'b1));
            end
            OP_TRACE: begin
                // restart: no joining span to the last column
                if (r.first_column) begin
                    prev_old  = r.old_sample;
                    prev_new  = r.new_sample;
                    trace_col = '0;
                end
                col = x_offset + trace_col;
                planned_cmds.push_back(mk_cmd(CMD_COLUMN_SET, {8'b0, col}, {8'b0, col},
                                              '0, '0, 1'b0));
                plan_span(prev_old, r.old_sample, erase_col, 1'b0);
                plan_span(prev_new, r.new_sample, r.color, 1'b1);
                prev_old  = r.old_sample;
                prev_new  = r.new_sample;
                trace_col = trace_col + 8'd1;
            end
            default: ;  // unknown op, no command and no state change
        endcase
    endfunction

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // mostly trace runs and sane windows, some inverted windows and dead ops
    function automatic in_item_t rand_req();
        in_item_t r;
        int       pick;
        r = mk_req(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), pick_sample(), pick_sample(),
                   1'($urandom));
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
            r.op           = OP_TRACE;
            r.first_column = ($urandom_range(0, 7) == 0);
        end else if (pick < 13) begin
            r.op = OP_RECT;
            if ($urandom_range(0, 3) != 0) begin
                r.x_end = r.x_start + 16'($urandom_range(0, 300));
                r.y_end = r.y_start + 16'($urandom_range(0, 300));
            end
        end else if (pick < 18) begin
            r.op = OP_PIXEL;
        end else begin
            r.op = OP_NONE;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [32:0] want,
                                        input logic [32:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // one request transaction; expected commands booked at acceptance
    task automatic send_req(input in_item_t r, input int typed_n);
        int gap;
        gap = source_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= r;
        plan_commands(r);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (typed_n == PREDICTED) begin
            foreach (planned_cmds[k]) pending_cmds.push_back(planned_cmds[k]);
        end else begin
            repeat (typed_n) pending_cmds.push_back(typed_cmds.pop_front());
        end
    endtask

    // hold the source until every owed command has come out
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_cmds.size() != 0) @(posedge aclk);
    endtask

    // drain, let a trailing dead op settle, then write both registers and
    // one unmapped index back to back
    task automatic program_regs(input logic [15:0] erase_data, input logic [15:0] xoff_data);
        logic [CFG_INDEX_W-1:0] idx [3];
        logic [CFG_DATA_W-1:0]  data [3];
        idx[0]  = CFG_ERASE_COLOR;
        data[0] = erase_data;
        idx[1]  = CFG_INDEX_W'($urandom_range(CFG_FIRST_UNUSED, 255));
        data[1] = 16'($urandom);
        idx[2]  = CFG_TRACE_X_OFFSET;
        data[2] = xoff_data;
        pause_until_drained();
        repeat (8) @(posedge aclk);
        for (int k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= data[k];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            if (idx[k] == CFG_ERASE_COLOR)
                erase_col = data[k];
            else if (idx[k] == CFG_TRACE_X_OFFSET)
                x_offset = data[k][7:0];
        end
        cfg_valid <= 1'b0;
    endtask

    // directed table, typed commands where they are obvious
    initial begin : directed_table
        // trace column right after reset: offset 25, all previous rows zero
        dir_reqs.push_back(mk_req(OP_TRACE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF, 8'd0, 8'd0, 1'b0));
        dir_typed_n.push_back(5);
        typed_cmds.push_back(mk_cmd(CMD_COLUMN_SET, 16'd25, 16'd25, '0, '0, 1'b0));
        typed_cmds.push_back(mk_cmd(CMD_PAGE_SET, '0, '0, '0, '0, 1'b0));
        typed_cmds.push_back(mk_cmd(CMD_MEM_WRITE, '0, '0, '0, 33'd1, 1'b0));
        typed_cmds.push_back(mk_cmd(CMD_PAGE_SET, '0, '0, '0, '0, 1'b0));
        typed_cmds.push_back(mk_cmd(CMD_MEM_WRITE, '0, '0, 16'hFFFF, 33'd1, 1'b1));
        // pixel at the origin
        dir_reqs.push_back(mk_req(OP_PIXEL, '0, '0, '0, '0, '0, '0, '0, 1'b0));
        dir_typed_n.push_back(3);
        typed_cmds.push_back(mk_cmd(CMD_COLUMN_SET, '0, '0, '0, '0, 1'b0));
        typed_cmds.push_back(mk_cmd(CMD_PAGE_SET, '0, '0, '0, '0, 1'b0));
        typed_cmds.push_back(mk_cmd(CMD_MEM_WRITE, '0, '0, '0, 33'd1, 1'b1));
        // pixel at the far corner
        dir_reqs.push_back(mk_req(OP_PIXEL, 16'hFFFF, 16'hFFFF, '0, '0, 16'hFFFF,
                                  8'hFF, 8'hFF, 1'b1));
        dir_typed_n.push_back(3);
        typed_cmds.push_back(mk_cmd(CMD_COLUMN_SET, 16'hFFFF, 16'hFFFF, '0, '0, 1'b0));
        typed_cmds.push_back(mk_cmd(CMD_PAGE_SET, 16'hFFFF, 16'hFFFF, '0, '0, 1'b0));
        typed_cmds.push_back(mk_cmd(CMD_MEM_WRITE, '0, '0, 16'hFFFF, 33'd1, 1'b1));
        // full-range rectangle, largest count 2^32
        dir_reqs.push_back(mk_req(OP_RECT, '0, '0, 16'hFFFF, 16'hFFFF, 16'h1234,
                                  '0, '0, 1'b0));
        dir_typed_n.push_back(3);
        typed_cmds.push_back(mk_cmd(CMD_COLUMN_SET, '0, 16'hFFFF, '0, '0, 1'b0));
        typed_cmds.push_back(mk_cmd(CMD_PAGE_SET, '0, 16'hFFFF, '0, '0, 1'b0));
        typed_cmds.push_back(mk_cmd(CMD_MEM_WRITE, '0, '0, 16'h1234,
                                    33'h1_0000_0000, 1'b1));
        // column end below start, nothing filled
        dir_reqs.push_back(mk_req(OP_RECT, 16'd10, 16'd0, 16'd9, 16'd5, 16'hABCD,
                                  '0, '0, 1'b0));
        dir_typed_n.push_back(3);
        typed_cmds.push_back(mk_cmd(CMD_COLUMN_SET, 16'd10, 16'd9, '0, '0, 1'b0));
        typed_cmds.push_back(mk_cmd(CMD_PAGE_SET, 16'd0, 16'd5, '0, '0, 1'b0));
        typed_cmds.push_back(mk_cmd(CMD_MEM_WRITE, '0, '0, 16'hABCD, 33'd0, 1'b1));
        // row end below start, nothing filled
        dir_reqs.push_back(mk_req(OP_RECT, 16'd3, 16'd9, 16'd3, 16'd8, 16'h5555,
                                  '0, '0, 1'b0));
        dir_typed_n.push_back(3);
        typed_cmds.push_back(mk_cmd(CMD_COLUMN_SET, 16'd3, 16'd3, '0, '0, 1'b0));
        typed_cmds.push_back(mk_cmd(CMD_PAGE_SET, 16'd9, 16'd8, '0, '0, 1'b0));
        typed_cmds.push_back(mk_cmd(CMD_MEM_WRITE, '0, '0, 16'h5555, 33'd0, 1'b1));
        // dead op with every bit set, restart flag must not act
        dir_reqs.push_back(mk_req(OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF, 8'hFF, 8'hFF, 1'b1));
        dir_typed_n.push_back(0);
        // the rest through the predictor
        dir_reqs.push_back(mk_req(OP_RECT, 16'd7, 16'd7, 16'd7, 16'd7, 16'h0F0F,
                                  '0, '0, 1'b0));
        dir_reqs.push_back(mk_req(OP_RECT, 16'd0, 16'd100, 16'hFFFF, 16'd100, 16'hF0F0,
                                  '0, '0, 1'b0));
        dir_reqs.push_back(mk_req(OP_RECT, 16'd40, 16'd2, 16'd40, 16'd300, 16'h8001,
                                  '0, '0, 1'b0));
        dir_reqs.push_back(mk_req(OP_TRACE, '0, '0, '0, '0, 16'h07E0, 8'hFF, 8'h00, 1'b1));
        dir_reqs.push_back(mk_req(OP_TRACE, '0, '0, '0, '0, 16'hF800, 8'h00, 8'hFF, 1'b0));
        dir_reqs.push_back(mk_req(OP_TRACE, '0, '0, '0, '0, 16'h001F, 8'h80, 8'h80, 1'b0));
        dir_reqs.push_back(mk_req(OP_NONE, '0, '0, '0, '0, '0, 8'h11, 8'h22, 1'b1));
        dir_reqs.push_back(mk_req(OP_TRACE, '0, '0, '0, '0, 16'h7BEF, 8'h80, 8'h81, 1'b0));
        dir_reqs.push_back(mk_req(OP_PIXEL, 16'd319, 16'd239, 16'd1, 16'd1, 16'hFFE0,
                                  8'h33, 8'h44, 1'b1));
        dir_reqs.push_back(mk_req(OP_TRACE, '0, '0, '0, '0, 16'h1111, 8'd17, 8'd200, 1'b1));
        dir_reqs.push_back(mk_req(OP_TRACE, '0, '0, '0, '0, 16'h2222, 8'd200, 8'd17, 1'b0));
        for (int k = 7; k < dir_reqs.size(); k++) dir_typed_n.push_back(PREDICTED);
    end

    // command sink with random back-pressure, checks against the owed queue
    initial begin : command_sink
        out_item_t want;
        int        gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (pending_cmds.size() == 0) begin
                $error("command with nothing owed: %h", m_payload);
                fail_count++;
            end else begin
                want = pending_cmds.pop_front();
                check_field("command", 33'(want.command), 33'(m_payload.command));
                check_field("first_param", 33'(want.first_param),
                            33'(m_payload.first_param));
                check_field("second_param", 33'(want.second_param),
                            33'(m_payload.second_param));
                check_field("fill_color", 33'(want.fill_color), 33'(m_payload.fill_color));
                check_field("fill_count", want.fill_count, m_payload.fill_count);
                check_field("last_of_run", 33'(want.last_of_run),
                            33'(m_payload.last_of_run));
            end
        end
    end

    // run guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        in_item_t r;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_payload   = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        source_idle = 1'b1;
        sink_idle   = 1'b1;
        erase_col   = '0;
        x_offset    = RESET_X_OFFSET;
        prev_old    = '0;
        prev_new    = '0;
        trace_col   = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table on reset settings
        for (int i = 0; i < dir_reqs.size(); i++) send_req(dir_reqs[i], dir_typed_n[i]);

        // top extremes: white erase, offset 255 so the column sum wraps
        program_regs(16'hFFFF, {8'($urandom), 8'hFF});
        for (int i = 0; i < 45; i++) begin
            send_req(rand_req(), PREDICTED);
            if (i % 25 == 24) pause_until_drained();
        end

        // bottom extremes, one long trace with no stalls
        program_regs(16'h0000, {8'($urandom), 8'h00});
        source_idle = 1'b0;
        sink_idle   = 1'b0;
        for (int i = 0; i < 45; i++) begin
            r              = rand_req();
            r.op           = OP_TRACE;
            r.first_column = (i == 0);
            send_req(r, PREDICTED);
        end

        // random settings, stall pattern changing in stretches
        program_regs(16'($urandom), 16'($urandom));
        for (int i = 0; i < 45; i++) begin
            if (i % 20 == 0) begin
                source_idle = 1'($urandom);
                sink_idle   = 1'($urandom);
            end
            send_req(rand_req(), PREDICTED);
            if (i % 25 == 24) pause_until_drained();
        end

        pause_until_drained();
        repeat (16) @(posedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
